[src/cc_cv_charger_cascaded_pi_top_assert.svh]
// Assertion macros for the CC/CV charger controller checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef CC_CV_CHARGER_CASCADED_PI_TOP_ASSERT_SVH
`define CC_CV_CHARGER_CASCADED_PI_TOP_ASSERT_SVH

// Clocked check, muted while reset is held.
`define CCPI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define CCPI_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ccpi_pkg.sv]
// Shared types, codes and fixed-point helpers of the CC/CV charger controller.
// No dependencies.
package ccpi_pkg;

    typedef struct packed {
        logic signed [15:0] voltage_sample;
        logic signed [15:0] current_sample;
        logic [1:0]         command;
    } ccpi_in_t;

    typedef struct packed {
        logic signed [15:0] drive;
        logic [1:0]         mode;
    } ccpi_out_t;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_CC   = 2'd1;
    localparam logic [1:0] MODE_CV   = 2'd2;

    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_DISABLE = 2'd1;
    localparam logic [1:0] CMD_ENABLE  = 2'd2;

    localparam logic [2:0] REG_VOLTAGE_TARGET = 3'd0;
    localparam logic [2:0] REG_CURRENT_TARGET = 3'd1;
    localparam logic [2:0] REG_VOLTAGE_BAND   = 3'd2;
    localparam logic [2:0] REG_CUTOFF_CURRENT = 3'd3;
    localparam logic [2:0] REG_CURRENT_KP     = 3'd4;
    localparam logic [2:0] REG_CURRENT_KI     = 3'd5;
    localparam logic [2:0] REG_VOLTAGE_KP     = 3'd6;
    localparam logic [2:0] REG_VOLTAGE_KI     = 3'd7;

    localparam logic [15:0] GAIN_KP_RESET = 16'd8192;
    localparam logic [15:0] GAIN_KI_RESET = 16'd1638;

    localparam logic signed [33:0] RND_HALF = 34'sd8192;
    localparam logic signed [20:0] Q15_MAX  = 21'sd32767;
    localparam logic signed [20:0] Q15_MIN  = -21'sd32768;

    typedef enum logic [1:0] {
        MUL_V_KI,
        MUL_V_KP,
        MUL_C_KI,
        MUL_C_KP
    } ccpi_mul_t;

    // Controller to datapath
    typedef struct packed {
        logic       capture;
        logic       seed_vint;
        logic       mul_en;
        ccpi_mul_t  mul_sel;
        logic       upd_vint;
        logic       upd_cint;
        logic       ref_load;
        logic       ref_cv;
        logic       clr_cint;
        logic       load_result;
        logic       drive_zero;
        logic [1:0] mode;
    } ccpi_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] command;
        logic       vs_ge_target;
        logic       vs_below_band;
        logic       cs_below_cutoff;
    } ccpi_stat_t;

    // Round a Q2.14-scaled product back to Q1.15, ties toward +infinity.
    function automatic logic signed [19:0] rnd14(input logic signed [33:0] p);
        logic signed [33:0] t;
        t = p + RND_HALF;
        return t[33:14];
    endfunction

    // Saturate to the Q1.15 range.
    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        logic signed [15:0] r;
        if (v > Q15_MAX) begin
            r = 16'sh7fff;
        end else if (v < Q15_MIN) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

[src/ccpi_dp.sv]
// Datapath of the CC/CV charger controller: config registers, sample capture,
// shared multiplier, integrators and result register. Depends on ccpi_pkg.
module ccpi_dp
    import ccpi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data,
    input  ccpi_in_t   sample,
    input  ccpi_cmd_t  cmd,
    output ccpi_stat_t stat,
    output ccpi_out_t  result
);

    logic [14:0] vt_reg, ct_reg, vb_reg, co_reg;
    logic [15:0] ckp_reg, cki_reg, vkp_reg, vki_reg;

    logic signed [15:0] vs_reg, cs_reg;
    logic [1:0]         code_reg;
    logic signed [15:0] vint_reg, vint_next;
    logic signed [15:0] cint_reg, cint_next;
    logic signed [15:0] iref_reg, iref_next;
    logic signed [33:0] prod_reg, prod_next;
    ccpi_out_t          result_reg, result_next;

    logic signed [16:0] verr, cerr, err_sel, gain_sel, band_lo;
    logic signed [19:0] prod_rnd;

    assign verr    = $signed({2'b00, vt_reg}) - $signed({vs_reg[15], vs_reg});
    assign cerr    = $signed({iref_reg[15], iref_reg}) - $signed({cs_reg[15], cs_reg});
    assign band_lo = $signed({2'b00, vt_reg}) - $signed({2'b00, vb_reg});
    assign prod_rnd = rnd14(prod_reg);

    assign stat.command         = code_reg;
    assign stat.vs_ge_target    = $signed({vs_reg[15], vs_reg}) >= $signed({2'b00, vt_reg});
    assign stat.vs_below_band   = $signed({vs_reg[15], vs_reg}) < band_lo;
    assign stat.cs_below_cutoff = $signed({cs_reg[15], cs_reg}) < $signed({2'b00, co_reg});

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_V_KI:
            begin
                err_sel  = verr;
                gain_sel = $signed({1'b0, vki_reg});
            end
            MUL_V_KP:
            begin
                err_sel  = verr;
                gain_sel = $signed({1'b0, vkp_reg});
            end
            MUL_C_KI:
            begin
                err_sel  = cerr;
                gain_sel = $signed({1'b0, cki_reg});
            end
            MUL_C_KP:
            begin
                err_sel  = cerr;
                gain_sel = $signed({1'b0, ckp_reg});
            end
            default:
            begin
                err_sel  = cerr;
                gain_sel = $signed({1'b0, ckp_reg});
            end
        endcase
        prod_next = cmd.mul_en ? err_sel * gain_sel : prod_reg;

        vint_next = vint_reg;
        if (cmd.seed_vint) begin
            vint_next = $signed({1'b0, ct_reg});
        end else if (cmd.upd_vint) begin
            vint_next = sat16($signed({{5{vint_reg[15]}}, vint_reg}) +
                              $signed({prod_rnd[19], prod_rnd}));
        end

        cint_next = cint_reg;
        if (cmd.clr_cint) begin
            cint_next = '0;
        end else if (cmd.upd_cint) begin
            cint_next = sat16($signed({{5{cint_reg[15]}}, cint_reg}) +
                              $signed({prod_rnd[19], prod_rnd}));
        end

        iref_next = iref_reg;
        if (cmd.ref_load) begin
            iref_next = cmd.ref_cv ?
                sat16($signed({prod_rnd[19], prod_rnd}) +
                      $signed({{5{vint_reg[15]}}, vint_reg})) :
                $signed({1'b0, ct_reg});
        end

        result_next = result_reg;
        if (cmd.load_result) begin
            result_next.mode  = cmd.mode;
            result_next.drive = cmd.drive_zero ? 16'sd0 :
                sat16($signed({prod_rnd[19], prod_rnd}) +
                      $signed({{5{cint_reg[15]}}, cint_reg}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vt_reg   <= '0;
            ct_reg   <= '0;
            vb_reg   <= '0;
            co_reg   <= '0;
            ckp_reg  <= GAIN_KP_RESET;
            cki_reg  <= GAIN_KI_RESET;
            vkp_reg  <= GAIN_KP_RESET;
            vki_reg  <= GAIN_KI_RESET;
            vint_reg <= '0;
            cint_reg <= '0;
        end else begin
            vint_reg <= vint_next;
            cint_reg <= cint_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_VOLTAGE_TARGET: vt_reg  <= cfg_data[14:0];
                    REG_CURRENT_TARGET: ct_reg  <= cfg_data[14:0];
                    REG_VOLTAGE_BAND:   vb_reg  <= cfg_data[14:0];
                    REG_CUTOFF_CURRENT: co_reg  <= cfg_data[14:0];
                    REG_CURRENT_KP:     ckp_reg <= cfg_data;
                    REG_CURRENT_KI:     cki_reg <= cfg_data;
                    REG_VOLTAGE_KP:     vkp_reg <= cfg_data;
                    REG_VOLTAGE_KI:     vki_reg <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture) begin
            vs_reg   <= sample.voltage_sample;
            cs_reg   <= sample.current_sample;
            code_reg <= sample.command;
        end
        prod_reg   <= prod_next;
        iref_reg   <= iref_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

[src/ccpi_ctrl.sv]
// Controller of the CC/CV charger controller: tick sequencer, enable flag,
// charge mode machine and result valid. Depends on ccpi_pkg.
module ccpi_ctrl
    import ccpi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_stall,
    output logic       result_valid,
    input  logic       result_stall,
    input  ccpi_stat_t stat,
    output ccpi_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_WAIT,
        S_MODE,
        S_VI,
        S_VP,
        S_REF,
        S_CI,
        S_CP,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    logic       en_reg, en_next;
    logic       valid_reg, valid_next;
    logic       load;

    always_comb
    begin
        logic       en_upd;
        logic [1:0] mode_upd;

        state_next = state_reg;
        mode_next  = mode_reg;
        en_next    = en_reg;
        cmd        = '0;
        cmd.mode   = mode_reg;
        load       = 1'b0;
        en_upd     = en_reg;
        mode_upd   = mode_reg;

        case (state_reg)
            S_WAIT:
            begin
                cmd.capture = sample_valid;
                if (sample_valid) begin
                    state_next = S_MODE;
                end
            end
            S_MODE:
            begin
                // latch the enable command first, then step the mode
                case (stat.command)
                    CMD_DISABLE: en_upd = 1'b0;
                    CMD_ENABLE:  en_upd = 1'b1;
                    default:     en_upd = en_reg;
                endcase
                case (mode_reg)
                    MODE_IDLE:
                    begin
                        if (en_upd) begin
                            mode_upd = MODE_CC;
                        end
                    end
                    MODE_CC:
                    begin
                        if (stat.vs_ge_target) begin
                            mode_upd      = MODE_CV;
                            cmd.seed_vint = 1'b1;
                        end
                    end
                    MODE_CV:
                    begin
                        if (stat.vs_below_band) begin
                            mode_upd = MODE_CC;
                        end else if (stat.cs_below_cutoff) begin
                            mode_upd = MODE_IDLE;
                            en_upd   = 1'b0;
                        end
                    end
                    default: mode_upd = MODE_IDLE;
                endcase
                if (!en_upd) begin
                    mode_upd = MODE_IDLE;
                end
                en_next   = en_upd;
                mode_next = mode_upd;
                case (mode_upd)
                    MODE_IDLE: state_next = S_OUT;
                    MODE_CV:   state_next = S_VI;
                    default:   state_next = S_REF;
                endcase
            end
            S_VI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_V_KI;
                state_next  = S_VP;
            end
            S_VP:
            begin
                cmd.upd_vint = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_V_KP;
                state_next   = S_REF;
            end
            S_REF:
            begin
                cmd.ref_load = 1'b1;
                cmd.ref_cv   = (mode_reg == MODE_CV);
                state_next   = S_CI;
            end
            S_CI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_C_KI;
                state_next  = S_CP;
            end
            S_CP:
            begin
                cmd.upd_cint = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_C_KP;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                // hold here until the result register is free
                load            = !valid_reg || !result_stall;
                cmd.load_result = load;
                cmd.drive_zero  = (mode_reg == MODE_IDLE);
                cmd.clr_cint    = (mode_reg == MODE_IDLE);
                if (load) begin
                    state_next = S_WAIT;
                end
            end
            default: state_next = S_WAIT;
        endcase

        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (valid_reg && !result_stall) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_WAIT;
            mode_reg  <= MODE_IDLE;
            en_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            en_reg    <= en_next;
            valid_reg <= valid_next;
        end
    end

    assign sample_stall = (state_reg != S_WAIT);
    assign result_valid = valid_reg;

endmodule

[src/cc_cv_charger_cascaded_pi_top.sv]
// Top level of the cascaded-PI CC/CV charger controller.
// Depends on ccpi_pkg, ccpi_ctrl and ccpi_dp.
//
//  channel  | direction | handshake                   | word
//  ---------+-----------+-----------------------------+--------------------------------
//  sample   | in        | sample_valid / sample_stall | voltage, current, command
//  result   | out       | result_valid / result_stall | drive, mode
//  cfg      | in        | cfg_we (no wait)            | cfg_index, cfg_data
//
//  Steps per word: wait, mode and output when the tick ends idle; reference
//  and current KI/KP between them in constant current, voltage KI/KP too in
//  constant voltage. Both PI loops share one 17x17 multiplier, two products each.
//  A stall on the result side holds the sequencer in its last step; a new
//  sample word is still taken while a finished result waits in its register.
//  Reset (rst_n low, asynchronous) returns to idle mode with the enable flag
//  clear, both integrators zero and the gains at 0.5 / 0.1.
module cc_cv_charger_cascaded_pi_top
    import ccpi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // sample words, one per control tick
    input  logic        sample_valid,
    output logic        sample_stall,
    input  ccpi_in_t    sample,
    // result words, exactly one per sample
    output logic        result_valid,
    input  logic        result_stall,
    output ccpi_out_t   result
);

    // command and status between sequencer and datapath
    ccpi_cmd_t  cmd;
    ccpi_stat_t stat;

    // Sequencer: owns the mode machine and the enable flag, steps the
    // datapath through the voltage loop (CV only) and the current loop.
    ccpi_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Datapath: captures the sample, compares it against the targets and
    // runs the PI arithmetic with a register after every product.
    ccpi_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule

[src/ccpi_checker.sv]
// Port-level checks of the CC/CV charger controller, bound to the top level.
// Depends on ccpi_pkg and cc_cv_charger_cascaded_pi_top_assert.svh.
`include "cc_cv_charger_cascaded_pi_top_assert.svh"

module ccpi_checker
    import ccpi_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      sample_valid,
    input logic      sample_stall,
    input logic      result_valid,
    input logic      result_stall,
    input ccpi_out_t result
);

    `CCPI_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid, "result word dropped while stalled")
    `CCPI_ASSERT(a_result_stable, result_valid && result_stall |=> $stable(result), "stalled result word changed")
    `CCPI_ASSERT(a_one_at_a_time, sample_valid && !sample_stall |=> sample_stall, "second sample word taken during a tick")
    `CCPI_ASSERT(a_idle_drive, result_valid && result.mode == MODE_IDLE |-> result.drive == 16'sd0, "nonzero drive in idle")
    `CCPI_ASSERT_RST(a_reset_empty, !rst_n |-> !result_valid, "result valid during reset")

endmodule

bind cc_cv_charger_cascaded_pi_top ccpi_checker u_ccpi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
